FILE: hw/rtl/mppe_pkg.sv
// Shared types, constants and sequencer states of the multi-peak profile evaluator.
// Used by every RTL file of the block except mppe_ram; depends on nothing.
package mppe_pkg;

  localparam int unsigned MAX_PEAKS_DEF = 8;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned SLOT_W      = 3;
  localparam int unsigned PCNT_W      = 4;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned IN_TDATA_W  = 136;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned OUT_TUSER_W = 2;
  localparam int unsigned ENTRY_W     = 3 * DATA_W;

  // Shared arithmetic unit widths
  localparam int unsigned MUL_W     = 64;
  localparam int unsigned PROD_W    = 128;
  localparam int unsigned DIV_DEN_W = 100;
  localparam int unsigned DIV_CNT_W = 8;

  localparam logic [DIV_CNT_W-1:0] DIV_FULL = 8'd128;
  localparam logic [DIV_CNT_W-1:0] DIV_HALF = 8'd64;

  // Fixed-point constants
  localparam logic [31:0] K_2_PI_Q32      = 32'd2734261102;
  localparam logic [31:0] S_SQRT_2_PI_Q32 = 32'd3426888095;
  localparam logic [63:0] LOG2E_Q60       = 64'h171547652B82FE17;
  localparam logic [63:0] LN2_Q64         = 64'hB17217F7D1CF79AC;
  localparam logic [4:0]  EXP_TERMS       = 5'd20;
  localparam logic [8:0]  GUARD_BITS      = 9'd8;
  localparam logic [8:0]  SHIFT_LIMIT     = 9'd100;

  typedef enum logic [1:0] {
    CFG_PROFILE    = 2'd0,
    CFG_PEAK_COUNT = 2'd1,
    CFG_OFFSET     = 2'd2,
    CFG_EMIT       = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_e;

  typedef enum logic {
    PROF_GAUSS   = 1'b0,
    PROF_LORENTZ = 1'b1
  } profile_e;

  typedef struct packed {
    profile_e           profile;
    logic [PCNT_W-1:0]  peak_count;
    logic [DATA_W-1:0]  offset;
    logic               emit_per_peak;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD,
    ST_PREP,
    ST_UU,
    ST_VV,
    ST_L_AV,
    ST_L_K,
    ST_L_DIV,
    ST_G_T,
    ST_G_Y,
    ST_G_Z,
    ST_G_ZR,
    ST_G_DN,
    ST_G_AS,
    ST_G_AM,
    ST_G_Q,
    ST_G_SH,
    ST_G_RND,
    ST_SIGN,
    ST_TERM,
    ST_EMIT,
    ST_TOTAL
  } state_e;

endpackage

FILE: hw/rtl/multi_peak_profile_evaluator_unit.sv
// Top level of the multi-peak profile evaluator: configuration registers, peak RAM
// and evaluation sequencer. Depends on mppe_pkg, mppe_ram, mppe_core.
//
// Usage:
//   Input stream (s_axis_*): tuser carries the command (load or evaluate). A load
//   beat writes one peak entry (area, center, width) into the peak RAM and produces
//   no result. An evaluate beat carries x and starts a run.
//   Output stream (m_axis_*): one beat per peak plus offset when per-peak output is
//   on and more than one peak is in use, then the total with tlast high. Config port:
//   cfg_we_i writes register cfg_idx_i (profile, peak count, offset, per-peak output)
//   with cfg_data_i; the user writes only while idle, which the block leaves unchecked.
// Arithmetic: the sequencer shares one 64x64 multiplier (four 32x32 steps) and one
//   bit-serial divider (128 or 64 quotient bits). A Lorentz peak is dominated by one
//   128-bit division; a Gauss peak is dominated by the twenty series steps of the
//   exponential (one multiply and one 64-bit division each) plus two 128-bit
//   divisions and a rounding shift; a Gauss peak far from its center ends after
//   the first division, and a zero-width peak skips the arithmetic. s_axis_tready
//   is low while an evaluation runs.
// Reset: configuration returns to Gauss, one peak, zero offset, per-peak output on.
//   The peak RAM is not cleared; entries are valid once loaded.
// Stall: the result register holds its beat while m_axis_tready is low and the
//   sequencer waits before writing the next result.
module multi_peak_profile_evaluator_unit #(
  parameter int unsigned MAX_PEAKS = mppe_pkg::MAX_PEAKS_DEF,
  parameter int unsigned FRAC_BITS = mppe_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // slave beat
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: peak_slot[2:0], area_in[34:3], center_in[66:35], width_in[98:67], x[130:99]
  input  logic [mppe_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: cmd[0]
  input  logic                             s_axis_tuser,
  // master beat
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: value[31:0], source_peak[34:32]
  output logic [mppe_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: is_total[0], overflow[1]
  output logic [mppe_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
  output logic                             m_axis_tlast,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [mppe_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mppe_pkg::DATA_W-1:0]      cfg_data_i
);
  import mppe_pkg::*;

  localparam int unsigned AW = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
  localparam int unsigned CW = $clog2(MAX_PEAKS + 1);
  localparam int unsigned IW = (CW > SLOT_W) ? CW : SLOT_W;

  cfg_t cfg_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.profile       <= PROF_GAUSS;
      cfg_q.peak_count    <= PCNT_W'(1);
      cfg_q.offset        <= '0;
      cfg_q.emit_per_peak <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PROFILE:    cfg_q.profile       <= profile_e'(cfg_data_i[0]);
        CFG_PEAK_COUNT: cfg_q.peak_count    <= cfg_data_i[PCNT_W-1:0];
        CFG_OFFSET:     cfg_q.offset        <= cfg_data_i;
        CFG_EMIT:       cfg_q.emit_per_peak <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input beat decode
  logic              in_acc, core_ready, ram_we;
  logic [IW-1:0]     slot_ext;
  logic [SLOT_W-1:0] slot;
  logic [DATA_W-1:0] area, center, width, xval;
  assign slot     = s_axis_tdata[2:0];
  assign area     = s_axis_tdata[34:3];
  assign center   = s_axis_tdata[66:35];
  assign width    = s_axis_tdata[98:67];
  assign xval     = s_axis_tdata[130:99];
  assign slot_ext = IW'(slot);
  assign in_acc   = s_axis_tvalid && core_ready;
  assign ram_we   = in_acc && (cmd_e'(s_axis_tuser) == CMD_LOAD) &&
                    (slot_ext < IW'(MAX_PEAKS));
  assign s_axis_tready = core_ready;

  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;

  mppe_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PEAKS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_ext[AW-1:0]),
    .wdata_i ({width, center, area}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mppe_core #(
    .MAX_PEAKS (MAX_PEAKS),
    .FRAC_BITS (FRAC_BITS),
    .AW        (AW)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .start_i     (in_acc && (cmd_e'(s_axis_tuser) == CMD_EVAL)),
    .x_i         (xval),
    .ready_o     (core_ready),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser),
    .m_tlast_o   (m_axis_tlast)
  );

endmodule

FILE: hw/rtl/mppe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the peak parameter entries; no package dependency.
module mppe_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, register the read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/mppe_mul.sv
// Shared 64x64 multiplier built from one 32x32 product per cycle.
// Depends on mppe_pkg for widths.
module mppe_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mppe_pkg::MUL_W-1:0]  a_i,
  input  logic [mppe_pkg::MUL_W-1:0]  b_i,
  output logic                        done_o,
  output logic [mppe_pkg::PROD_W-1:0] prod_o
);
  import mppe_pkg::*;

  logic [MUL_W-1:0]  a_q, b_q, p_q;
  logic [PROD_W-1:0] acc_q, addend;
  logic [2:0]        cnt_q;
  logic              busy_q, done_q;
  logic [31:0]       ha, hb;

  // Pick the half-word pair for this step
  always_comb begin
    case (cnt_q)
      3'd0: begin
        ha = a_q[31:0];  hb = b_q[31:0];
      end
      3'd1: begin
        ha = a_q[63:32]; hb = b_q[31:0];
      end
      3'd2: begin
        ha = a_q[31:0];  hb = b_q[63:32];
      end
      default: begin
        ha = a_q[63:32]; hb = b_q[63:32];
      end
    endcase
  end

  // Align the previous partial product
  always_comb begin
    case (cnt_q)
      3'd1:    addend = PROD_W'(p_q);
      3'd2:    addend = PROD_W'(p_q) << 32;
      3'd3:    addend = PROD_W'(p_q) << 32;
      default: addend = PROD_W'(p_q) << 64;
    endcase
  end

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 3'd4);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Partial products and accumulation
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      p_q <= {32'd0, ha} * {32'd0, hb};
      if (cnt_q != 3'd0) begin
        acc_q <= acc_q + addend;
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

FILE: hw/rtl/mppe_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on mppe_pkg for widths; the numerator is left-aligned by the caller.
module mppe_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [mppe_pkg::PROD_W-1:0]    num_i,
  input  logic [mppe_pkg::DIV_DEN_W-1:0] den_i,
  input  logic [mppe_pkg::DIV_CNT_W-1:0] iters_i,
  output logic                           done_o,
  output logic [mppe_pkg::PROD_W-1:0]    quo_o
);
  import mppe_pkg::*;

  logic [PROD_W-1:0]    n_q;
  logic [DIV_DEN_W-1:0] r_q, d_q;
  logic [DIV_DEN_W:0]   rs;
  logic                 ge;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;

  // Trial subtract
  assign rs = {r_q, n_q[PROD_W-1]};
  assign ge = (rs >= {1'b0, d_q});

  // Iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DIV_CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= iters_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Shift remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= num_i;
      d_q <= den_i;
      r_q <= '0;
    end else if (busy_q) begin
      n_q <= {n_q[PROD_W-2:0], ge};
      r_q <= ge ? DIV_DEN_W'(rs - {1'b0, d_q}) : rs[DIV_DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = n_q;

endmodule

FILE: hw/rtl/mppe_core.sv
// Evaluation sequencer: walks the peaks through the shared multiplier and divider,
// sums the terms and drives the result register. Depends on mppe_pkg, mppe_mul, mppe_div.
module mppe_core #(
  parameter int unsigned MAX_PEAKS = mppe_pkg::MAX_PEAKS_DEF,
  parameter int unsigned FRAC_BITS = mppe_pkg::FRAC_BITS_DEF,
  parameter int unsigned AW        = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mppe_pkg::cfg_t                   cfg_i,
  input  logic                             start_i,
  input  logic [mppe_pkg::DATA_W-1:0]      x_i,
  output logic                             ready_o,
  output logic                             ram_re_o,
  output logic [AW-1:0]                    ram_raddr_o,
  input  logic [mppe_pkg::ENTRY_W-1:0]     ram_rdata_i,
  output logic                             m_tvalid_o,
  input  logic                             m_tready_i,
  output logic [mppe_pkg::OUT_TDATA_W-1:0] m_tdata_o,
  output logic [mppe_pkg::OUT_TUSER_W-1:0] m_tuser_o,
  output logic                             m_tlast_o
);
  import mppe_pkg::*;

  localparam int unsigned CW = $clog2(MAX_PEAKS + 1);
  localparam int unsigned PW = (CW > PCNT_W) ? CW : PCNT_W;
  localparam int unsigned IW = (CW > SLOT_W) ? CW : SLOT_W;
  localparam int unsigned SW = 33 + CW;

  state_e state_q, state_d;
  logic   iss_q;

  logic [CW-1:0]     i_q, cnt_q;
  logic [DATA_W-1:0] x_q, am_q, v_q;
  logic [32:0]       u_q;
  logic              neg_q;
  logic [63:0]       uu_q, vv_q;
  logic [PROD_W-1:0] ra_q, mag_q;
  logic [7:0]        k_q;
  logic [61:0]       z_q;
  logic [62:0]       r_q;
  logic [4:0]        nn_q;
  logic [6:0]        sh_q;
  logic [DATA_W-1:0] term_q;
  logic              tflag_q;
  logic [SW-1:0]     sum_q;
  logic              any_q;

  logic              ov_q, od_tot_q, od_last_q, od_ovf_q;
  logic [DATA_W-1:0] od_val_q;
  logic [SLOT_W-1:0] od_src_q;

  // Shared unit handshakes
  logic              mul_start, mul_done, div_start, div_done;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_prod, div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_CNT_W-1:0] div_iters;

  mppe_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  mppe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .iters_i (div_iters),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Peak count limited to the table size
  logic [PW-1:0] pc_ext, n_lim;
  logic [CW-1:0] n_start;
  assign pc_ext  = PW'(cfg_i.peak_count);
  assign n_lim   = (pc_ext > PW'(MAX_PEAKS)) ? PW'(MAX_PEAKS) : pc_ext;
  assign n_start = CW'(n_lim);

  // Entry fields and magnitudes
  logic [DATA_W-1:0] a_rd, c_rd, w_rd, v_abs, a_abs;
  logic [32:0]       d_rd, u_abs;
  assign a_rd  = ram_rdata_i[DATA_W-1:0];
  assign c_rd  = ram_rdata_i[2*DATA_W-1:DATA_W];
  assign w_rd  = ram_rdata_i[3*DATA_W-1:2*DATA_W];
  assign d_rd  = {x_q[DATA_W-1], x_q} - {c_rd[DATA_W-1], c_rd};
  assign u_abs = d_rd[32] ? (~d_rd + 33'd1) : d_rd;
  assign v_abs = w_rd[DATA_W-1] ? (~w_rd + 32'd1) : w_rd;
  assign a_abs = a_rd[DATA_W-1] ? (~a_rd + 32'd1) : a_rd;

  // Lorentz denominator and rounded numerator
  logic [66:0]          qsum;
  logic [DIV_DEN_W-1:0] den_l;
  logic [PROD_W-1:0]    num_l;
  assign qsum  = {1'b0, uu_q, 2'b00} + {3'b000, vv_q};
  assign den_l = DIV_DEN_W'({qsum, 32'd0});
  assign num_l = ra_q + PROD_W'({qsum, 31'd0});

  // Gauss helpers
  logic [32:0] m_val;
  logic [8:0]  s_g;
  logic        t_big;
  assign m_val = 33'((64'(r_q) + 64'h2000_0000) >> 30);
  assign s_g   = 9'(k_q) + GUARD_BITS;
  assign t_big = |div_quo[PROD_W-1:39];

  // Term clipping
  logic mag_gt_min, mag_gt_max;
  assign mag_gt_min = (|mag_q[PROD_W-1:32]) | (mag_q[31] & (|mag_q[30:0]));
  assign mag_gt_max = |mag_q[PROD_W-1:31];

  // Per-peak value plus offset
  logic [32:0]       pv;
  logic [DATA_W-1:0] pv_sat;
  logic              pv_ovf;
  assign pv = {term_q[DATA_W-1], term_q} + {cfg_i.offset[DATA_W-1], cfg_i.offset};
  always_comb begin
    pv_ovf = (pv[32] != pv[31]);
    if (!pv_ovf) begin
      pv_sat = pv[31:0];
    end else if (pv[32]) begin
      pv_sat = 32'h8000_0000;
    end else begin
      pv_sat = 32'h7FFF_FFFF;
    end
  end

  // Saturated total
  logic              sum_hi, sum_lo;
  logic [DATA_W-1:0] sum_sat;
  assign sum_hi = ~sum_q[SW-1] & (|sum_q[SW-2:31]);
  assign sum_lo = sum_q[SW-1] & ~(&sum_q[SW-2:31]);
  always_comb begin
    if (sum_hi) begin
      sum_sat = 32'h7FFF_FFFF;
    end else if (sum_lo) begin
      sum_sat = 32'h8000_0000;
    end else begin
      sum_sat = sum_q[31:0];
    end
  end

  logic          last_peak, emit_on, out_free, out_load;
  logic [IW-1:0] i_ext;
  assign last_peak = (CW'(i_q + 1'b1) == cnt_q);
  assign emit_on   = cfg_i.emit_per_peak && (cnt_q > CW'(1));
  assign out_free  = !ov_q || m_tready_i;
  assign i_ext     = IW'(i_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start_i) state_d = (n_start == '0) ? ST_TOTAL : ST_RD;
      ST_RD:    state_d = ST_PREP;
      ST_PREP:  state_d = (w_rd == '0) ? ST_TERM : ST_UU;
      ST_UU:    if (mul_done) state_d = ST_VV;
      ST_VV: begin
        if (mul_done) state_d = (cfg_i.profile == PROF_LORENTZ) ? ST_L_AV : ST_G_T;
      end
      ST_L_AV:  if (mul_done) state_d = ST_L_K;
      ST_L_K:   if (mul_done) state_d = ST_L_DIV;
      ST_L_DIV: if (div_done) state_d = ST_SIGN;
      ST_G_T:   if (div_done) state_d = t_big ? ST_SIGN : ST_G_Y;
      ST_G_Y:   if (mul_done) state_d = ST_G_Z;
      ST_G_Z:   if (mul_done) state_d = ST_G_ZR;
      ST_G_ZR:  if (mul_done) state_d = ST_G_DN;
      ST_G_DN:  if (div_done) state_d = (nn_q == 5'd1) ? ST_G_AS : ST_G_ZR;
      ST_G_AS:  if (mul_done) state_d = ST_G_AM;
      ST_G_AM:  if (mul_done) state_d = ST_G_Q;
      ST_G_Q:   if (div_done) state_d = (s_g >= SHIFT_LIMIT) ? ST_SIGN : ST_G_SH;
      ST_G_SH:  if (sh_q == 7'd1) state_d = ST_G_RND;
      ST_G_RND: state_d = ST_SIGN;
      ST_SIGN:  state_d = ST_TERM;
      ST_TERM: begin
        if (emit_on) state_d = ST_EMIT;
        else state_d = last_peak ? ST_TOTAL : ST_RD;
      end
      ST_EMIT:  if (out_free) state_d = last_peak ? ST_TOTAL : ST_RD;
      ST_TOTAL: if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Unit operands, starts and strobes
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_iters = '0;
    ram_re_o  = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_RD: ram_re_o = 1'b1;
      ST_UU: begin
        mul_start = !iss_q; mul_a = MUL_W'(u_q); mul_b = MUL_W'(u_q);
      end
      ST_VV: begin
        mul_start = !iss_q; mul_a = MUL_W'(v_q); mul_b = MUL_W'(v_q);
      end
      ST_L_AV: begin
        mul_start = !iss_q; mul_a = MUL_W'(am_q); mul_b = MUL_W'(v_q);
      end
      ST_L_K: begin
        mul_start = !iss_q; mul_a = ra_q[MUL_W-1:0]; mul_b = MUL_W'(K_2_PI_Q32);
      end
      ST_L_DIV: begin
        div_start = !iss_q; div_num = num_l; div_den = den_l; div_iters = DIV_FULL;
      end
      ST_G_T: begin
        div_start = !iss_q;
        div_num   = PROD_W'({uu_q, 33'd0});
        div_den   = DIV_DEN_W'(vv_q);
        div_iters = DIV_FULL;
      end
      ST_G_Y: begin
        mul_start = !iss_q; mul_a = ra_q[MUL_W-1:0]; mul_b = LOG2E_Q60;
      end
      ST_G_Z: begin
        mul_start = !iss_q; mul_a = ra_q[MUL_W-1:0]; mul_b = LN2_Q64;
      end
      ST_G_ZR: begin
        mul_start = !iss_q; mul_a = MUL_W'(z_q); mul_b = MUL_W'(r_q);
      end
      ST_G_DN: begin
        div_start = !iss_q;
        div_num   = {ra_q[63:0], 64'd0};
        div_den   = DIV_DEN_W'(nn_q);
        div_iters = DIV_HALF;
      end
      ST_G_AS: begin
        mul_start = !iss_q; mul_a = MUL_W'(am_q); mul_b = MUL_W'(S_SQRT_2_PI_Q32);
      end
      ST_G_AM: begin
        mul_start = !iss_q; mul_a = ra_q[MUL_W-1:0]; mul_b = MUL_W'(m_val);
      end
      ST_G_Q: begin
        div_start = !iss_q;
        div_num   = ra_q;
        div_den   = DIV_DEN_W'({v_q, 56'd0});
        div_iters = DIV_FULL;
      end
      ST_EMIT:  out_load = out_free;
      ST_TOTAL: out_load = out_free;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      iss_q   <= 1'b0;
      ov_q    <= 1'b0;
      i_q     <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (mul_start || div_start) begin
        iss_q <= 1'b1;
      end else if (mul_done || div_done) begin
        iss_q <= 1'b0;
      end
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (m_tready_i) begin
        ov_q <= 1'b0;
      end
      if (state_q == ST_IDLE && start_i) begin
        i_q   <= '0;
        cnt_q <= n_start;
      end else if ((state_q == ST_TERM && !emit_on && !last_peak) ||
                   (state_q == ST_EMIT && out_free && !last_peak)) begin
        i_q <= i_q + 1'b1;
      end
    end
  end

  // Datapath captures
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          x_q   <= x_i;
          sum_q <= {{(SW-DATA_W){cfg_i.offset[DATA_W-1]}}, cfg_i.offset};
          any_q <= 1'b0;
        end
      end
      ST_PREP: begin
        am_q    <= a_abs;
        u_q     <= u_abs;
        v_q     <= v_abs;
        neg_q   <= a_rd[DATA_W-1] ^ w_rd[DATA_W-1];
        term_q  <= '0;
        tflag_q <= (w_rd == '0);
      end
      ST_UU:    if (mul_done) uu_q <= mul_prod[63:0];
      ST_VV:    if (mul_done) vv_q <= mul_prod[63:0];
      ST_L_AV:  if (mul_done) ra_q <= PROD_W'(mul_prod[63:0]);
      ST_L_K:   if (mul_done) ra_q <= mul_prod << FRAC_BITS;
      ST_L_DIV: if (div_done) mag_q <= div_quo;
      ST_G_T: begin
        if (div_done) begin
          if (t_big) mag_q <= '0;
          else ra_q <= div_quo;
        end
      end
      ST_G_Y: begin
        if (mul_done) begin
          k_q  <= mul_prod[99:92];
          ra_q <= PROD_W'(mul_prod[91:60]);
        end
      end
      ST_G_Z: begin
        if (mul_done) begin
          z_q  <= mul_prod[95:34];
          r_q  <= 63'h4000_0000_0000_0000;
          nn_q <= EXP_TERMS;
        end
      end
      ST_G_ZR:  if (mul_done) ra_q <= PROD_W'(mul_prod[123:62]);
      ST_G_DN: begin
        if (div_done) begin
          r_q <= 63'h4000_0000_0000_0000 - div_quo[62:0];
          if (nn_q != 5'd1) nn_q <= nn_q - 5'd1;
        end
      end
      ST_G_AS:  if (mul_done) ra_q <= PROD_W'(mul_prod[63:0]);
      ST_G_AM:  if (mul_done) ra_q <= mul_prod << FRAC_BITS;
      ST_G_Q: begin
        if (div_done) begin
          mag_q <= (s_g >= SHIFT_LIMIT) ? '0 : div_quo;
          sh_q  <= 7'(s_g - 9'd1);
        end
      end
      ST_G_SH: begin
        mag_q <= mag_q >> 1;
        sh_q  <= sh_q - 7'd1;
      end
      ST_G_RND: mag_q <= (mag_q + PROD_W'(1)) >> 1;
      ST_SIGN: begin
        if (neg_q) begin
          term_q  <= mag_gt_min ? 32'h8000_0000 : (~mag_q[31:0] + 32'd1);
          tflag_q <= tflag_q | mag_gt_min;
        end else begin
          term_q  <= mag_gt_max ? 32'h7FFF_FFFF : mag_q[31:0];
          tflag_q <= tflag_q | mag_gt_max;
        end
      end
      ST_TERM: begin
        sum_q <= sum_q + {{(SW-DATA_W){term_q[DATA_W-1]}}, term_q};
        any_q <= any_q | tflag_q;
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (state_q == ST_TOTAL) begin
        od_val_q  <= sum_sat;
        od_src_q  <= '0;
        od_tot_q  <= 1'b1;
        od_last_q <= 1'b1;
        od_ovf_q  <= any_q | sum_hi | sum_lo;
      end else begin
        od_val_q  <= pv_sat;
        od_src_q  <= i_ext[SLOT_W-1:0];
        od_tot_q  <= 1'b0;
        od_last_q <= 1'b0;
        od_ovf_q  <= tflag_q | pv_ovf;
      end
    end
  end

  assign ready_o     = (state_q == ST_IDLE);
  assign ram_raddr_o = i_q[AW-1:0];
  assign m_tvalid_o  = ov_q;
  assign m_tdata_o   = {5'd0, od_src_q, od_val_q};
  assign m_tuser_o   = {od_ovf_q, od_tot_q};
  assign m_tlast_o   = od_last_q;

  // The two shared units never start together
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(mul_start && div_start))
    else $error("multiplier and divider started in the same cycle");

  // The peak index stays below the count while peaks are walked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && state_q != ST_TOTAL) |-> (i_q < cnt_q))
    else $error("peak index out of range");

  // A unit result only arrives for an issued operation
  assert property (@(posedge clk_i) disable iff (!rst_ni) (mul_done || div_done) |-> iss_q)
    else $error("unit done without an issued operation");

  // The rounding shift never runs with an empty count
  assert property (@(posedge clk_i) disable iff (!rst_ni) (state_q == ST_G_SH) |-> (sh_q != 7'd0))
    else $error("shift count exhausted");

  // A held result is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_load |-> (!ov_q || m_tready_i))
    else $error("result register overwritten while stalled");

endmodule

FILE: verif/multi_peak_profile_evaluator_unit_tb.sv
// Self-checking testbench of the multi-peak profile evaluator: loads peaks, sweeps
// configurations and compares every output beat against an in-bench predictor.
// Depends on mppe_pkg and multi_peak_profile_evaluator_unit.
module multi_peak_profile_evaluator_unit_tb;
  import mppe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [127:0] u128;

  typedef struct {
    cmd_e        cmd;
    logic [2:0]  slot;
    logic [31:0] area;
    logic [31:0] center;
    logic [31:0] width;
    logic [31:0] x;
  } peak_cmd_t;

  typedef struct {
    logic signed [31:0] value;
    logic [2:0]         src;
    logic               total;
    logic               last;
    logic               ovf;
  } profile_beat_t;

  localparam int unsigned STALL_LIMIT = 100000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [DATA_W-1:0] cfg_data_i = '0;

  peak_cmd_t     cmd_queue[$];
  profile_beat_t beats_due[$];
  peak_cmd_t     cur_cmd;
  int            err_count = 0;
  int            issued = 0;
  int            src_gap = 0;
  int            sink_gap = 0;
  int unsigned   quiet_cycles = 0;

  // Mirror of the block's registers and peak RAM
  logic signed [31:0] area_tab[8];
  logic signed [31:0] center_tab[8];
  logic signed [31:0] width_tab[8];
  logic               cfg_prof = 1'b0;
  logic [3:0]         cfg_cnt = 4'd1;
  logic signed [31:0] cfg_off = '0;
  logic               cfg_emit = 1'b1;

  multi_peak_profile_evaluator_unit uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // 2^-g for g in Q0.32 by a truncated series, result in Q.32
  function automatic logic [63:0] exp2_frac(logic [31:0] g);
    u128 p;
    logic [63:0] z, r, zr;
    p = {96'd0, g} * {64'd0, LN2_Q64};
    z = p[97:34];
    r = 64'd1 << 62;
    for (int n = 20; n >= 1; n--) begin
      p = {64'd0, z} * {64'd0, r};
      zr = p[125:62];
      r = (64'd1 << 62) - zr / 64'(n);
    end
    return (r + (64'd1 << 29)) >> 30;
  endfunction

  // One clipped peak term at x; flag on clip or zero width
  function automatic longint peak_value(int i, logic signed [31:0] xv, inout bit flag);
    longint a, c, w, d, s;
    logic [63:0] u, v, am, t64, k, m;
    u128 mag, num, den, t, y, q;
    bit neg;
    a = area_tab[i];
    c = center_tab[i];
    w = width_tab[i];
    d = longint'(xv) - c;
    u = d < 0 ? -d : d;
    v = w < 0 ? -w : w;
    am = a < 0 ? -a : a;
    neg = (a < 0) != (w < 0);
    if (v == 0) begin
      flag = 1'b1;
      return 0;
    end
    if (cfg_prof == PROF_LORENTZ) begin
      t64 = am * v;
      num = ({64'd0, t64} * {96'd0, K_2_PI_Q32}) << FRAC_BITS_DEF;
      t64 = u * u;
      den = {64'd0, t64} << 2;
      t64 = v * v;
      den = (den + {64'd0, t64}) << 32;
      mag = (num + (den >> 1)) / den;
    end else begin
      t64 = u * u;
      t = {64'd0, t64} << 33;
      t64 = v * v;
      t = t / {64'd0, t64};
      if (t >= (u128'(1) << 39)) begin
        mag = '0;
      end else begin
        y = (t * {64'd0, LOG2E_Q60}) >> 60;
        k = {32'd0, y[63:32]};
        m = exp2_frac(y[31:0]);
        t64 = am * {32'd0, S_SQRT_2_PI_Q32};
        num = ({64'd0, t64} * {64'd0, m}) << FRAC_BITS_DEF;
        q = num / ({64'd0, v} << 56);
        s = longint'(k) + 8;
        if (s >= 100) mag = '0;
        else mag = (q + (u128'(1) << (s - 1))) >> s;
      end
    end
    if (neg) begin
      if (mag > 128'h8000_0000) begin
        flag = 1'b1;
        return -longint'(64'h8000_0000);
      end
      return -longint'(mag[63:0]);
    end
    if (mag > 128'h7FFF_FFFF) begin
      flag = 1'b1;
      return 64'h7FFF_FFFF;
    end
    return longint'(mag[63:0]);
  endfunction

  function automatic longint clamp32(longint val, inout bit flag);
    if (val > 64'sh7FFF_FFFF) begin
      flag = 1'b1;
      return 64'sh7FFF_FFFF;
    end
    if (val < -64'sh8000_0000) begin
      flag = 1'b1;
      return -64'sh8000_0000;
    end
    return val;
  endfunction

  // Apply one accepted command: store a peak or queue the beats of an evaluation
  task automatic absorb_cmd(peak_cmd_t pc);
    int n;
    longint sum, term, pv;
    bit any, f;
    profile_beat_t b;
    if (pc.cmd == CMD_LOAD) begin
      area_tab[pc.slot] = pc.area;
      center_tab[pc.slot] = pc.center;
      width_tab[pc.slot] = pc.width;
      return;
    end
    n = cfg_cnt > 8 ? 8 : cfg_cnt;
    sum = cfg_off;
    any = 1'b0;
    for (int i = 0; i < n; i++) begin
      f = 1'b0;
      term = peak_value(i, pc.x, f);
      sum += term;
      any |= f;
      if (cfg_emit && n > 1) begin
        pv = clamp32(term + cfg_off, f);
        b.value = pv[31:0];
        b.src = 3'(i);
        b.total = 1'b0;
        b.last = 1'b0;
        b.ovf = f;
        beats_due.push_back(b);
      end
    end
    sum = clamp32(sum, any);
    b.value = sum[31:0];
    b.src = '0;
    b.total = 1'b1;
    b.last = 1'b1;
    b.ovf = any;
    beats_due.push_back(b);
  endtask

  // Input driver: hold a beat until accepted, then wait a drawn gap
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) absorb_cmd(cur_cmd);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          cur_cmd = cmd_queue.pop_front();
          s_axis_tdata <= {5'd0, cur_cmd.x, cur_cmd.width, cur_cmd.center, cur_cmd.area,
                           cur_cmd.slot};
          s_axis_tuser <= cur_cmd.cmd;
          s_axis_tvalid <= 1'b1;
          src_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check each beat against the oldest expectation, stall at random
  always @(posedge clk_i) begin
    profile_beat_t e;
    longint dv;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (beats_due.size() == 0) begin
          $error("unexpected beat value %0h", m_axis_tdata[31:0]);
          err_count++;
        end else begin
          e = beats_due.pop_front();
          dv = longint'($signed(m_axis_tdata[31:0])) - longint'(e.value);
          if (dv > 2 || dv < -2) begin
            $error("value: expected %0d actual %0d", e.value, $signed(m_axis_tdata[31:0]));
            err_count++;
          end
          if (m_axis_tdata[34:32] !== e.src) begin
            $error("source_peak: expected %0d actual %0d", e.src, m_axis_tdata[34:32]);
            err_count++;
          end
          if (m_axis_tuser[0] !== e.total) begin
            $error("is_total: expected %0b actual %0b", e.total, m_axis_tuser[0]);
            err_count++;
          end
          if (m_axis_tlast !== e.last) begin
            $error("last: expected %0b actual %0b", e.last, m_axis_tlast);
            err_count++;
          end
          if (m_axis_tuser[1] !== e.ovf) begin
            $error("overflow: expected %0b actual %0b", e.ovf, m_axis_tuser[1]);
            err_count++;
          end
        end
        sink_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("multi_peak_profile_evaluator_unit_tb: done, errors");
      $finish;
    end
  end

  function automatic logic [31:0] pick_q();
    case ($urandom_range(0, 6))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0;
          3: return 32'h1;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_width();
    logic [31:0] w;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom;
      default: begin
        w = 32'($urandom_range(32'h0000_4000, 32'h0040_0000));
        return $urandom_range(0, 1) ? -w : w;
      end
    endcase
  endfunction

  task automatic push_load(logic [2:0] slot, logic [31:0] a, logic [31:0] c,
                           logic [31:0] w);
    peak_cmd_t pc;
    pc.cmd = CMD_LOAD;
    pc.slot = slot;
    pc.area = a;
    pc.center = c;
    pc.width = w;
    pc.x = $urandom;
    cmd_queue.push_back(pc);
    issued++;
  endtask

  task automatic push_eval(logic [31:0] x);
    peak_cmd_t pc;
    pc.cmd = CMD_EVAL;
    pc.slot = 3'($urandom);
    pc.area = $urandom;
    pc.center = $urandom;
    pc.width = $urandom;
    pc.x = x;
    cmd_queue.push_back(pc);
    issued++;
  endtask

  // Evaluate close to a stored center most of the time
  function automatic logic [31:0] pick_x();
    if ($urandom_range(0, 3) == 0) return pick_q();
    return center_tab[$urandom_range(0, 7)] + 32'($urandom_range(0, 32'h0008_0000))
           - 32'h0004_0000;
  endfunction

  // Wait for an idle block, then write all four registers
  task automatic write_regs(logic p, logic [3:0] cnt, logic [31:0] off, logic em);
    wait (cmd_queue.size() == 0 && !s_axis_tvalid && beats_due.size() == 0);
    repeat (30) @(posedge clk_i);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_PROFILE;
    cfg_data_i <= {31'd0, p};
    @(posedge clk_i);
    cfg_idx_i <= CFG_PEAK_COUNT;
    cfg_data_i <= {28'd0, cnt};
    @(posedge clk_i);
    cfg_idx_i <= CFG_OFFSET;
    cfg_data_i <= off;
    @(posedge clk_i);
    cfg_idx_i <= CFG_EMIT;
    cfg_data_i <= {31'd0, em};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_prof = p;
    cfg_cnt = cnt;
    cfg_off = off;
    cfg_emit = em;
  endtask

  initial begin
    int batch;
    logic [3:0] cnt;
    logic [31:0] off;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fill every slot, including zero, negative and extreme widths and areas
    push_load(3'd0, 32'h0001_0000, 32'h0, 32'h0001_0000);
    push_load(3'd1, 32'h8000_0000, 32'h0002_0000, 32'hFFFF_0000);
    push_load(3'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001);
    push_load(3'd3, 32'h0003_0000, 32'h8000_0000, 32'h0);
    push_load(3'd4, 32'hFFFE_0000, 32'hFFFF_8000, 32'h7FFF_FFFF);
    push_load(3'd5, 32'h0000_0001, 32'h0001_8000, 32'h8000_0000);
    push_load(3'd6, 32'h0010_0000, 32'h0, 32'h0000_8000);
    push_load(3'd7, 32'hFFFF_FFFF, 32'h0005_0000, 32'h0004_0000);
    push_eval(32'h0);
    push_eval(32'h7FFF_FFFF);
    push_eval(32'h8000_0000);
    push_eval(32'h0000_8000);

    // Lorentz, all peaks, offset at maximum
    write_regs(PROF_LORENTZ, 4'd8, 32'h7FFF_FFFF, 1'b1);
    push_eval(32'h0);
    push_eval(32'h8000_0000);
    push_eval(32'h0002_0000);
    // Gauss, count above range, offset at minimum, totals only
    write_regs(PROF_GAUSS, 4'd15, 32'h8000_0000, 1'b0);
    push_eval(32'h0);
    push_eval(32'h0005_0000);
    // No peaks in use: offset alone
    write_regs(PROF_LORENTZ, 4'd0, 32'h1234_5678, 1'b1);
    push_eval(32'h0);
    push_eval($urandom);
    // Two peaks with per-peak beats, small offset
    write_regs(PROF_GAUSS, 4'd2, 32'hFFFF_0000, 1'b1);
    push_eval(32'h0001_0000);
    push_eval(32'h0);

    // Random phases: mostly few peaks, occasionally all of them
    while (issued < 340) begin
      case ($urandom_range(0, 9))
        8: cnt = 4'd8;
        9: cnt = 4'($urandom_range(0, 15));
        6, 7: cnt = 4'($urandom_range(3, 4));
        default: cnt = 4'($urandom_range(1, 2));
      endcase
      off = ($urandom_range(0, 3) == 0) ? $urandom
                                         : 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
      write_regs(1'($urandom_range(0, 1)), cnt, off, 1'($urandom_range(0, 1)));
      batch = (cnt > 4) ? 10 : 36;
      for (int j = 0; j < batch; j++) begin
        if ($urandom_range(0, 1) == 0)
          push_load(3'($urandom), pick_q(), pick_q(), pick_width());
        else
          push_eval(pick_x());
      end
    end

    wait (cmd_queue.size() == 0 && !s_axis_tvalid && beats_due.size() == 0);
    repeat (50) @(posedge clk_i);
    if (err_count == 0) begin
      $display("multi_peak_profile_evaluator_unit_tb: done, clean");
    end else begin
      $display("multi_peak_profile_evaluator_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
